>>> sv/ssram_pkg.sv
// shared types and constants for the spi serial sram slave
// no dependencies; used by ssram_ctrl and spi_serial_sram_slave
`default_nettype none

package ssram_pkg;

	// array size
	localparam int ADDR_BITS = 17;
	localparam int MEM_DEPTH = 1 << ADDR_BITS;

	// spi commands
	localparam logic [7:0] CMD_WRMR  = 8'h01;
	localparam logic [7:0] CMD_WRITE = 8'h02;
	localparam logic [7:0] CMD_READ  = 8'h03;
	localparam logic [7:0] CMD_RDMR  = 8'h05;

	// mode register after reset: sequential mode
	localparam logic [7:0] MODE_RESET = 8'h40;

	// transaction phase, one-hot
	typedef enum logic [5:0] {
		PH_CMD      = 6'b000001,
		PH_ADDR_HI  = 6'b000010,
		PH_ADDR_MID = 6'b000100,
		PH_ADDR_LO  = 6'b001000,
		PH_DATA     = 6'b010000,
		PH_IGNORE   = 6'b100000
	} phase_t;

	// where the returned byte comes from
	typedef enum logic [1:0] {
		SRC_ZERO = 2'd0,
		SRC_MODE = 2'd1,
		SRC_MEM  = 2'd2
	} miso_src_t;

	// per-item request from the command decoder to the datapath
	typedef struct packed {
		logic                 wr_en;
		logic                 rd_en;
		logic [ADDR_BITS-1:0] addr;
		miso_src_t            src;
		logic [7:0]           mode;
	} mem_req_t;

endpackage

`default_nettype wire

>>> sv/spi_serial_sram_slave.sv
// top level of the spi serial sram slave: byte array, result stage, output register
// depends on ssram_pkg and ssram_ctrl
`default_nettype none

// One item is one spi byte exchange (op = 0) or one deselect (op = 1), and
// each item returns exactly one miso byte. The block takes an item in every
// cycle unless stage 1 and the output register are both full and out_ready
// is low; a result passes the registered read port of the 128 KiB byte
// array, then the output register. The array has no reset:
// reading an address never written returns whatever it holds. The mode
// register resets to 0x40 and is only stored and read back; addressing is
// always sequential, wrapping at the end of the array.
module spi_serial_sram_slave (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       op,
	input  wire logic [7:0] mosi_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      miso_byte
);

	logic                     accept;
	logic                     s1_move;
	ssram_pkg::mem_req_t      req;
	logic                     valid_s1;
	ssram_pkg::miso_src_t     src_s1;
	logic [7:0]               mode_s1;
	logic [7:0]               rdata_s1;
	logic [7:0]               data_s1;
	logic                     out_valid_q;
	logic [7:0]               miso_q;
	logic [7:0]               mem [ssram_pkg::MEM_DEPTH];

	// handshake: stage 1 drains into the output register when that is free
	assign s1_move  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || s1_move;
	assign accept   = in_valid && in_ready;

	ssram_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (op),
		.mosi_byte (mosi_byte),
		.req       (req)
	);

	// byte array, at most one access per accepted item
	always_ff @(posedge clk) begin
		if (accept && req.wr_en) begin
			mem[req.addr] <= mosi_byte;
		end
		if (accept && req.rd_en) begin
			rdata_s1 <= mem[req.addr];
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1  <= req.src;
			mode_s1 <= req.mode;
		end
	end

	// pick the returned byte
	always_comb begin
		case (src_s1)
			ssram_pkg::SRC_MODE: data_s1 = mode_s1;
			ssram_pkg::SRC_MEM:  data_s1 = rdata_s1;
			default:             data_s1 = 8'h00;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			miso_q <= data_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign miso_byte = miso_q;

endmodule

`default_nettype wire

>>> sv/ssram_ctrl.sv
// command decoder: phase machine, address register and mode register
// depends on ssram_pkg
`default_nettype none

module ssram_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              op,
	input  wire logic [7:0]        mosi_byte,
	output ssram_pkg::mem_req_t    req
);

	ssram_pkg::phase_t                 phase_q, phase_d;
	logic [7:0]                        cmd_q, cmd_d;
	logic [ssram_pkg::ADDR_BITS-1:0]   addr_q, addr_d;
	logic [7:0]                        mode_q, mode_d;
	logic [ssram_pkg::ADDR_BITS+7:0]   addr_shift;

	// address byte shifted in from the right, high bits dropped
	assign addr_shift = {addr_q, mosi_byte};

	// next state and request for the item now offered
	always_comb begin
		phase_d = phase_q;
		cmd_d   = cmd_q;
		addr_d  = addr_q;
		mode_d  = mode_q;
		req.wr_en = 1'b0;
		req.rd_en = 1'b0;
		req.addr  = addr_q;
		req.src   = ssram_pkg::SRC_ZERO;
		req.mode  = mode_q;
		if (op) begin
			phase_d = ssram_pkg::PH_CMD;
		end else begin
			unique case (phase_q)
				ssram_pkg::PH_CMD: begin
					cmd_d = mosi_byte;
					if (mosi_byte == ssram_pkg::CMD_READ ||
					    mosi_byte == ssram_pkg::CMD_WRITE) begin
						addr_d  = '0;
						phase_d = ssram_pkg::PH_ADDR_HI;
					end else if (mosi_byte == ssram_pkg::CMD_RDMR ||
					             mosi_byte == ssram_pkg::CMD_WRMR) begin
						phase_d = ssram_pkg::PH_DATA;
					end else begin
						phase_d = ssram_pkg::PH_IGNORE;
					end
				end
				ssram_pkg::PH_ADDR_HI: begin
					addr_d  = addr_shift[ssram_pkg::ADDR_BITS-1:0];
					phase_d = ssram_pkg::PH_ADDR_MID;
				end
				ssram_pkg::PH_ADDR_MID: begin
					addr_d  = addr_shift[ssram_pkg::ADDR_BITS-1:0];
					phase_d = ssram_pkg::PH_ADDR_LO;
				end
				ssram_pkg::PH_ADDR_LO: begin
					addr_d  = addr_shift[ssram_pkg::ADDR_BITS-1:0];
					phase_d = ssram_pkg::PH_DATA;
				end
				ssram_pkg::PH_DATA: begin
					if (cmd_q == ssram_pkg::CMD_RDMR) begin
						req.src = ssram_pkg::SRC_MODE;
					end else if (cmd_q == ssram_pkg::CMD_WRMR) begin
						mode_d  = mosi_byte;
						phase_d = ssram_pkg::PH_IGNORE;
					end else if (cmd_q == ssram_pkg::CMD_READ) begin
						req.rd_en = 1'b1;
						req.src   = ssram_pkg::SRC_MEM;
						addr_d    = addr_q + 1'b1;
					end else if (cmd_q == ssram_pkg::CMD_WRITE) begin
						req.wr_en = 1'b1;
						addr_d    = addr_q + 1'b1;
					end else begin
						phase_d = ssram_pkg::PH_IGNORE;
					end
				end
				ssram_pkg::PH_IGNORE: begin
					phase_d = ssram_pkg::PH_IGNORE;
				end
				default: begin
					phase_d = ssram_pkg::PH_IGNORE;
				end
			endcase
		end
	end

	// state registers, updated only on an accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ssram_pkg::PH_CMD;
			cmd_q   <= '0;
			addr_q  <= '0;
			mode_q  <= ssram_pkg::MODE_RESET;
		end else if (accept) begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			addr_q  <= addr_d;
			mode_q  <= mode_d;
		end
	end

endmodule

`default_nettype wire

>>> tb/sv/tb_spi_serial_sram_slave.sv
// self-checking testbench for spi_serial_sram_slave: directed table, then random transactions
// depends on ssram_pkg and spi_serial_sram_slave; carries its own byte-level model of the device
`default_nettype none

module tb_spi_serial_sram_slave;
	import ssram_pkg::*;

	// item opcodes
	localparam bit OP_XFER  = 1'b0;
	localparam bit OP_DESEL = 1'b1;

	localparam logic [23:0] ADDR_MASK   = 24'(MEM_DEPTH - 1);
	localparam int          TARGET_ITEMS = 1900;
	localparam int          HOLD_CYCLES  = 300;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       op = OP_XFER;
	logic [7:0] mosi_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] miso_byte;

	// typed-in expectation travels with the item
	logic       row_typed = 1'b0;
	logic [7:0] row_want = 8'h00;

	spi_serial_sram_slave uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.mosi_byte(mosi_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.miso_byte(miso_byte)
	);

	always #2 clk = ~clk;

	// device model state
	phase_t      dev_phase = PH_CMD;
	logic [7:0]  dev_cmd = 8'h00;
	logic [23:0] dev_addr = 24'h0;
	logic [7:0]  dev_mode = MODE_RESET;
	logic [7:0]  sram_image [MEM_DEPTH];

	logic [7:0] miso_expect_q [$];
	int         mismatch_count = 0;
	int         useful_items = 0;
	bit         steady = 1'b0;
	bit         hold_req = 1'b0;
	bit         hold_done = 1'b0;

	// runs of consecutive written entries, so reads never touch unwritten memory
	typedef struct {
		int base;
		int len;
	} run_t;
	run_t wr_runs [$];

	// one exchange or deselect through the device model, returns the miso byte
	function automatic logic [7:0] sram_exchange(input bit o, input logic [7:0] b);
		logic [7:0] r;
		r = 8'h00;
		if (o == OP_DESEL) begin
			dev_phase = PH_CMD;
			return r;
		end
		case (dev_phase)
			PH_CMD: begin
				dev_cmd = b;
				if (b == CMD_READ || b == CMD_WRITE) begin
					dev_addr = 24'h0;
					dev_phase = PH_ADDR_HI;
				end else if (b == CMD_RDMR || b == CMD_WRMR) begin
					dev_phase = PH_DATA;
				end else begin
					dev_phase = PH_IGNORE;
				end
			end
			PH_ADDR_HI: begin
				dev_addr = {dev_addr[15:0], b};
				dev_phase = PH_ADDR_MID;
			end
			PH_ADDR_MID: begin
				dev_addr = {dev_addr[15:0], b};
				dev_phase = PH_ADDR_LO;
			end
			PH_ADDR_LO: begin
				dev_addr = {dev_addr[15:0], b} & ADDR_MASK;
				dev_phase = PH_DATA;
			end
			PH_DATA: begin
				case (dev_cmd)
					CMD_RDMR: r = dev_mode;
					CMD_WRMR: begin
						dev_mode = b;
						dev_phase = PH_IGNORE;
					end
					CMD_READ: begin
						r = sram_image[dev_addr[ADDR_BITS-1:0]];
						dev_addr = (dev_addr + 24'd1) & ADDR_MASK;
					end
					CMD_WRITE: begin
						sram_image[dev_addr[ADDR_BITS-1:0]] = b;
						dev_addr = (dev_addr + 24'd1) & ADDR_MASK;
					end
					default: dev_phase = PH_IGNORE;
				endcase
			end
			default: dev_phase = PH_IGNORE;
		endcase
		return r;
	endfunction

	// result check first, then queue the prediction for an accepted item
	always @(posedge clk) begin : scoreboard
		logic [7:0] want;
		logic [7:0] pred;
		if (arst_n && out_valid && out_ready) begin
			if (miso_expect_q.size() == 0) begin
				$display("%0t: miso_byte %02h with no item pending", $time, miso_byte);
				mismatch_count++;
			end else begin
				want = miso_expect_q.pop_front();
				if (miso_byte !== want) begin
					$display("%0t: miso_byte expected %02h got %02h", $time, want, miso_byte);
					mismatch_count++;
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			pred = sram_exchange(op, mosi_byte);
			miso_expect_q.push_back(row_typed ? row_want : pred);
		end
	end

	// receiver: random stalls, one long hold-off, a steady stretch
	initial begin : rx_drive
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				out_ready <= 1'b1;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 12);
			end
		end
	end

	// offer one item and wait for it to be taken
	task automatic send_item(input bit o, input logic [7:0] b, input bit typed,
			input logic [7:0] want);
		while (!steady && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		mosi_byte <= b;
		row_typed <= typed;
		row_want  <= want;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(OP_XFER, b, 1'b0, 8'h00);
	endtask

	task automatic deselect();
		send_item(OP_DESEL, 8'($urandom_range(255)), 1'b0, 8'h00);
	endtask

	// three address bytes, array address in the low bits, junk above
	task automatic send_addr(input int a);
		logic [23:0] v;
		v = 24'($urandom);
		v[ADDR_BITS-1:0] = a[ADDR_BITS-1:0];
		send_byte(v[23:16]);
		send_byte(v[15:8]);
		send_byte(v[7:0]);
	endtask

	task automatic do_write();
		int base;
		int n;
		if ($urandom_range(9) == 0)
			base = MEM_DEPTH - 1 - $urandom_range(5);
		else
			base = $urandom_range(MEM_DEPTH - 1);
		n = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
		send_byte(CMD_WRITE);
		send_addr(base);
		repeat (n) send_byte(8'($urandom_range(255)));
		deselect();
		wr_runs.push_back('{base: base, len: n});
		useful_items += n + 5;
	endtask

	task automatic do_read();
		run_t r;
		int off;
		int n;
		if (wr_runs.size() == 0) begin
			do_write();
			return;
		end
		r = wr_runs[$urandom_range(wr_runs.size() - 1)];
		off = $urandom_range(r.len - 1);
		n = $urandom_range(r.len - off, 1);
		send_byte(CMD_READ);
		send_addr((r.base + off) % MEM_DEPTH);
		repeat (n) send_byte(8'($urandom_range(255)));
		deselect();
		useful_items += n + 5;
	endtask

	task automatic do_rdmr();
		int n;
		n = $urandom_range(4, 1);
		send_byte(CMD_RDMR);
		repeat (n) send_byte(8'($urandom_range(255)));
		deselect();
		useful_items += n + 2;
	endtask

	// mode write, sometimes trailed by ignored bytes
	task automatic do_wrmr();
		send_byte(CMD_WRMR);
		send_byte(8'($urandom_range(255)));
		repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)));
		deselect();
		useful_items += 3;
	endtask

	// unknown command, everything after it ignored
	task automatic do_unknown();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (c == CMD_READ || c == CMD_WRITE || c == CMD_RDMR || c == CMD_WRMR);
		send_byte(c);
		repeat ($urandom_range(4)) send_byte(8'($urandom_range(255)));
		deselect();
	endtask

	// read or write cut off during the address, or a stray deselect
	task automatic do_abort();
		case ($urandom_range(2))
			0: send_byte(CMD_WRITE);
			1: send_byte(CMD_READ);
			default: ;
		endcase
		repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)));
		deselect();
	endtask

	typedef struct {
		bit         o;
		logic [7:0] b;
		bit         typed;
		logic [7:0] want;
	} dir_row_t;

	// directed rows: mode after reset, mode set to all ones, wrap at the top of the array,
	// masked address, unknown command, bytes after mode write
	dir_row_t dir_rows [29] = '{
		'{OP_XFER,  CMD_RDMR,  1'b1, 8'h00},
		'{OP_XFER,  8'hA5,     1'b1, MODE_RESET},
		'{OP_DESEL, 8'hFF,     1'b1, 8'h00},
		'{OP_XFER,  CMD_WRMR,  1'b1, 8'h00},
		'{OP_XFER,  8'hFF,     1'b1, 8'h00},
		'{OP_XFER,  8'h3C,     1'b1, 8'h00},
		'{OP_DESEL, 8'h00,     1'b1, 8'h00},
		'{OP_XFER,  CMD_RDMR,  1'b1, 8'h00},
		'{OP_XFER,  8'h00,     1'b1, 8'hFF},
		'{OP_DESEL, 8'h00,     1'b1, 8'h00},
		'{OP_XFER,  CMD_WRITE, 1'b1, 8'h00},
		'{OP_XFER,  8'hFF,     1'b1, 8'h00},
		'{OP_XFER,  8'hFF,     1'b1, 8'h00},
		'{OP_XFER,  8'hFF,     1'b1, 8'h00},
		'{OP_XFER,  8'h00,     1'b1, 8'h00},
		'{OP_XFER,  8'hFF,     1'b1, 8'h00},
		'{OP_XFER,  8'h5A,     1'b1, 8'h00},
		'{OP_DESEL, 8'h00,     1'b1, 8'h00},
		'{OP_XFER,  CMD_READ,  1'b1, 8'h00},
		'{OP_XFER,  8'hFE,     1'b1, 8'h00},
		'{OP_XFER,  8'hFF,     1'b1, 8'h00},
		'{OP_XFER,  8'hFF,     1'b1, 8'h00},
		'{OP_XFER,  8'h00,     1'b0, 8'h00},
		'{OP_XFER,  8'h00,     1'b0, 8'h00},
		'{OP_XFER,  8'h00,     1'b0, 8'h00},
		'{OP_DESEL, 8'h00,     1'b1, 8'h00},
		'{OP_XFER,  8'h00,     1'b1, 8'h00},
		'{OP_XFER,  CMD_READ,  1'b1, 8'h00},
		'{OP_DESEL, 8'hFF,     1'b1, 8'h00}
	};

	initial begin : stim
		int k;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].o, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
		// directed write covered the top entry and wrapped into entries 0 and 1
		wr_runs.push_back('{base: MEM_DEPTH - 1, len: 3});

		// random transactions, mostly well-formed
		while (useful_items < TARGET_ITEMS) begin
			if (useful_items >= 300)
				hold_req = 1'b1;
			steady = (useful_items >= 900 && useful_items < 1200);
			k = $urandom_range(99);
			if (k < 35)
				do_write();
			else if (k < 65)
				do_read();
			else if (k < 75)
				do_rdmr();
			else if (k < 83)
				do_wrmr();
			else if (k < 90)
				do_unknown();
			else
				do_abort();
		end
		in_valid <= 1'b0;
		steady = 1'b0;

		// drain, then let the pipeline settle
		while (miso_expect_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_spi_serial_sram_slave OK");
		else
			$display("tb_spi_serial_sram_slave NOT OK");
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#2000000;
		$display("tb_spi_serial_sram_slave NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
sv/ssram_pkg.sv
sv/ssram_ctrl.sv
sv/spi_serial_sram_slave.sv
tb/sv/tb_spi_serial_sram_slave.sv
